FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the buffer cache checks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define LBC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("buffer cache assertion failed");

// next-cycle implication
`define LBC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("buffer cache assertion failed");

`endif

FILE: hw/rtl/lbc_pkg.sv
// ----------------------------------------------------------------------------
// Buffer cache package
// Sizes, operation and status codes, payload and control structs.
// ----------------------------------------------------------------------------
package lbc_pkg;

    localparam int NUM_SLOTS = 32;
    localparam int SIDX_W    = $clog2(NUM_SLOTS);
    localparam int CNT_W     = $clog2(NUM_SLOTS + 1);

    localparam int OP_W   = 3;
    localparam int DEV_W  = 8;
    localparam int BLK_W  = 32;
    localparam int SLOT_W = 5;
    localparam int RC_W   = 8;
    localparam int STAT_W = 2;

    localparam logic [OP_W-1:0] OP_READ    = 3'd0;
    localparam logic [OP_W-1:0] OP_DIRTY   = 3'd1;
    localparam logic [OP_W-1:0] OP_RELEASE = 3'd2;
    localparam logic [OP_W-1:0] OP_PIN     = 3'd3;
    localparam logic [OP_W-1:0] OP_UNPIN   = 3'd4;

    localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NOFREE = 2'd1;
    localparam logic [STAT_W-1:0] STAT_UNDER  = 2'd2;
    localparam logic [STAT_W-1:0] STAT_OVER   = 2'd3;

    localparam logic [RC_W-1:0] RC_MAX = '1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FWD,
        ST_BWD,
        ST_SLOT,
        ST_FIND,
        ST_DONE
    } lbc_state_t;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [DEV_W-1:0]  dev;
        logic [BLK_W-1:0]  blockno;
        logic [SLOT_W-1:0] slot;
    } lbc_in_t;

    typedef struct packed {
        logic [SLOT_W-1:0] buf_slot;
        logic              hit;
        logic              fill_req;
        logic              wb_req;
        logic [DEV_W-1:0]  out_dev;
        logic [BLK_W-1:0]  out_blockno;
        logic [RC_W-1:0]   ref_count;
        logic [STAT_W-1:0] status;
    } lbc_out_t;

    typedef struct packed {
        logic [DEV_W-1:0] dev;
        logic [BLK_W-1:0] blk;
    } lbc_tag_t;

    typedef struct packed {
        logic              wr_en;
        logic [SIDX_W-1:0] wr_addr;
        lbc_tag_t          wr_tag;
        logic [SIDX_W-1:0] rd_addr;
    } lbc_tag_req_t;

endpackage

FILE: hw/rtl/lbc_tag_store.sv
// ----------------------------------------------------------------------------
// Buffer cache tag store
// One-write, one-read tag memory with registered read; entries never
// written read as zero.
// ----------------------------------------------------------------------------
module lbc_tag_store (
    input  logic                 clk,
    input  logic                 rst_n,
    input  lbc_pkg::lbc_tag_req_t req,
    output lbc_pkg::lbc_tag_t    rd_tag
);
    import lbc_pkg::*;

    lbc_tag_t               mem_reg [NUM_SLOTS];
    logic [NUM_SLOTS-1:0]   written_reg;
    lbc_tag_t               rd_data_reg;
    logic                   rd_written_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem_reg[req.wr_addr] <= req.wr_tag;
        end
        rd_data_reg <= mem_reg[req.rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg    <= '0;
            rd_written_reg <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
            begin
                written_reg[req.wr_addr] <= 1'b1;
            end
            rd_written_reg <= written_reg[req.rd_addr];
        end
    end

    assign rd_tag = rd_written_reg ? rd_data_reg : '0;

endmodule

FILE: hw/rtl/lru_block_buffer_cache.sv
// ----------------------------------------------------------------------------
// LRU block buffer cache
// Tag lookup, victim reclaim and reference counting over a recency list.
// ----------------------------------------------------------------------------
// One transfer in, one transfer out per item; in_ready is low while an item is
// worked. A read scans the recency list from the most recent end through the
// single tag memory read port, one slot a cycle, then walks back from the least
// recent end over the reference counts, one slot a cycle, for a victim. Mark
// dirty, pin, unpin and release pass through the slot state to the done state;
// a release that drops the count to zero goes through a find state first, which
// locates the slot in the recency list and moves it to the front. A finished
// result waits in the output register while the next transfer is taken; an item
// that finishes while that register still holds an untaken result stalls until
// it is taken.
module lru_block_buffer_cache (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  lbc_pkg::lbc_in_t  in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output lbc_pkg::lbc_out_t out_data
);
    import lbc_pkg::*;

    lbc_state_t        state_reg, state_next;
    logic [OP_W-1:0]   op_reg, op_next;
    logic [DEV_W-1:0]  dev_reg, dev_next;
    logic [BLK_W-1:0]  blk_reg, blk_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic              pend_vld_reg, pend_vld_next;
    logic [SIDX_W-1:0] pend_slot_reg, pend_slot_next;
    lbc_out_t          res_reg, res_next;
    logic              out_valid_reg;
    lbc_out_t          out_data_reg;

    logic [RC_W-1:0]      cnt_reg [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] valid_reg;
    logic [NUM_SLOTS-1:0] dirty_reg;
    logic [SIDX_W-1:0]    rec_reg [NUM_SLOTS];

    lbc_tag_req_t      tag_req;
    lbc_tag_t          tag_rd;

    logic [SIDX_W-1:0] idx_s;
    logic [SIDX_W-1:0] s_idx;
    logic [SIDX_W-1:0] rec_at_idx;
    logic [SIDX_W-1:0] cnt_addr;
    logic [RC_W-1:0]   cnt_cur;
    logic              tag_match;
    logic              in_xfer;
    logic              in_slot_bad;

    logic              cnt_we;
    logic [RC_W-1:0]   cnt_wd;
    logic              valid_we;
    logic              dirty_we;
    logic              dirty_wd;
    logic              rec_shift;
    logic              out_load;

    lbc_tag_store u_tag_store (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (tag_req),
        .rd_tag (tag_rd)
    );

    assign idx_s       = idx_reg[SIDX_W-1:0];
    assign s_idx       = slot_reg[SIDX_W-1:0];
    assign rec_at_idx  = rec_reg[idx_s];
    assign in_xfer     = in_valid && in_ready;
    assign in_slot_bad = (32'(in_data.slot) >= 32'(NUM_SLOTS));
    assign tag_match   = pend_vld_reg && (tag_rd.dev == dev_reg) && (tag_rd.blk == blk_reg);

    always_comb
    begin
        case (state_reg)
            ST_FWD:  cnt_addr = pend_slot_reg;
            ST_BWD:  cnt_addr = rec_at_idx;
            default: cnt_addr = s_idx;
        endcase
    end

    assign cnt_cur = cnt_reg[cnt_addr];

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_data.op == OP_READ)
                        state_next = ST_FWD;
                    else if (in_data.op > OP_UNPIN || in_slot_bad)
                        state_next = ST_DONE;
                    else
                        state_next = ST_SLOT;
                end
            end
            ST_FWD:
            begin
                if (tag_match)
                    state_next = ST_DONE;
                else if (idx_reg == CNT_W'(NUM_SLOTS))
                    state_next = ST_BWD;
            end
            ST_BWD:
            begin
                if (cnt_cur == '0 || idx_reg == '0)
                    state_next = ST_DONE;
            end
            ST_SLOT:
            begin
                if (op_reg == OP_RELEASE && cnt_cur == RC_W'(1))
                    state_next = ST_FIND;
                else
                    state_next = ST_DONE;
            end
            ST_FIND:
            begin
                if (rec_at_idx == s_idx || idx_s == SIDX_W'(NUM_SLOTS - 1))
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        in_ready       = (state_reg == ST_IDLE);
        op_next        = op_reg;
        dev_next       = dev_reg;
        blk_next       = blk_reg;
        slot_next      = slot_reg;
        idx_next       = idx_reg;
        pend_vld_next  = pend_vld_reg;
        pend_slot_next = pend_slot_reg;
        res_next       = res_reg;
        cnt_we         = 1'b0;
        cnt_wd         = cnt_cur;
        valid_we       = 1'b0;
        dirty_we       = 1'b0;
        dirty_wd       = 1'b0;
        rec_shift      = 1'b0;
        out_load       = 1'b0;
        tag_req.wr_en   = 1'b0;
        tag_req.wr_addr = rec_at_idx;
        tag_req.wr_tag  = '{dev: dev_reg, blk: blk_reg};
        tag_req.rd_addr = s_idx;

        case (state_reg)
            ST_IDLE:
            begin
                tag_req.rd_addr = in_data.slot[SIDX_W-1:0];
                if (in_xfer)
                begin
                    op_next       = in_data.op;
                    dev_next      = in_data.dev;
                    blk_next      = in_data.blockno;
                    slot_next     = in_data.slot;
                    idx_next      = '0;
                    pend_vld_next = 1'b0;
                    res_next      = '0;
                    if (in_data.op != OP_READ && in_data.op <= OP_UNPIN && in_slot_bad)
                        res_next.buf_slot = in_data.slot;
                end
            end
            ST_FWD:
            begin
                tag_req.rd_addr = rec_at_idx;
                if (tag_match)
                begin
                    res_next.buf_slot    = SLOT_W'(pend_slot_reg);
                    res_next.hit         = 1'b1;
                    res_next.out_dev     = dev_reg;
                    res_next.out_blockno = blk_reg;
                    if (cnt_cur == RC_MAX)
                    begin
                        res_next.ref_count = cnt_cur;
                        res_next.status    = STAT_OVER;
                    end
                    else
                    begin
                        cnt_we             = 1'b1;
                        cnt_wd             = cnt_cur + RC_W'(1);
                        res_next.ref_count = cnt_wd;
                        if (!valid_reg[cnt_addr])
                        begin
                            res_next.fill_req = 1'b1;
                            valid_we          = 1'b1;
                            dirty_we          = 1'b1;
                        end
                    end
                end
                else if (idx_reg != CNT_W'(NUM_SLOTS))
                begin
                    pend_vld_next  = 1'b1;
                    pend_slot_next = rec_at_idx;
                    idx_next       = idx_reg + CNT_W'(1);
                end
                else
                begin
                    idx_next = CNT_W'(NUM_SLOTS - 1);
                end
            end
            ST_BWD:
            begin
                if (cnt_cur == '0)
                begin
                    tag_req.wr_en        = 1'b1;
                    cnt_we               = 1'b1;
                    cnt_wd               = RC_W'(1);
                    valid_we             = 1'b1;
                    dirty_we             = 1'b1;
                    res_next.buf_slot    = SLOT_W'(rec_at_idx);
                    res_next.fill_req    = 1'b1;
                    res_next.out_dev     = dev_reg;
                    res_next.out_blockno = blk_reg;
                    res_next.ref_count   = RC_W'(1);
                end
                else if (idx_reg != '0)
                begin
                    idx_next = idx_reg - CNT_W'(1);
                end
                else
                begin
                    res_next.status = STAT_NOFREE;
                end
            end
            ST_SLOT:
            begin
                res_next.buf_slot    = slot_reg;
                res_next.out_dev     = tag_rd.dev;
                res_next.out_blockno = tag_rd.blk;
                res_next.ref_count   = cnt_cur;
                idx_next             = '0;
                case (op_reg)
                    OP_DIRTY:
                    begin
                        dirty_we = 1'b1;
                        dirty_wd = 1'b1;
                    end
                    OP_RELEASE:
                    begin
                        if (dirty_reg[s_idx])
                        begin
                            res_next.wb_req = 1'b1;
                            dirty_we        = 1'b1;
                        end
                        if (cnt_cur == '0)
                        begin
                            res_next.status = STAT_UNDER;
                        end
                        else
                        begin
                            cnt_we             = 1'b1;
                            cnt_wd             = cnt_cur - RC_W'(1);
                            res_next.ref_count = cnt_wd;
                        end
                    end
                    OP_PIN:
                    begin
                        if (cnt_cur == RC_MAX)
                        begin
                            res_next.status = STAT_OVER;
                        end
                        else
                        begin
                            cnt_we             = 1'b1;
                            cnt_wd             = cnt_cur + RC_W'(1);
                            res_next.ref_count = cnt_wd;
                        end
                    end
                    OP_UNPIN:
                    begin
                        if (cnt_cur == '0)
                        begin
                            res_next.status = STAT_UNDER;
                        end
                        else
                        begin
                            cnt_we             = 1'b1;
                            cnt_wd             = cnt_cur - RC_W'(1);
                            res_next.ref_count = cnt_wd;
                        end
                    end
                    default: ;
                endcase
            end
            ST_FIND:
            begin
                if (rec_at_idx == s_idx)
                    rec_shift = 1'b1;
                else
                    idx_next = idx_reg + CNT_W'(1);
            end
            ST_DONE:
            begin
                out_load = !out_valid_reg || out_ready;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pend_vld_reg  <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            pend_vld_reg <= pend_vld_next;
            idx_reg      <= idx_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        dev_reg       <= dev_next;
        blk_reg       <= blk_next;
        slot_reg      <= slot_next;
        pend_slot_reg <= pend_slot_next;
        res_reg       <= res_next;
        if (out_load)
            out_data_reg <= res_reg;
    end

    // slot state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            dirty_reg <= '0;
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                cnt_reg[i] <= '0;
                rec_reg[i] <= SIDX_W'(NUM_SLOTS - 1 - i);
            end
        end
        else
        begin
            if (cnt_we)
                cnt_reg[cnt_addr] <= cnt_wd;
            if (valid_we)
                valid_reg[cnt_addr] <= 1'b1;
            if (dirty_we)
                dirty_reg[cnt_addr] <= dirty_wd;
            if (rec_shift)
            begin
                rec_reg[0] <= s_idx;
                for (int i = 1; i < NUM_SLOTS; i++)
                begin
                    if (SIDX_W'(i) <= idx_s)
                        rec_reg[i] <= rec_reg[i-1];
                end
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

FILE: hw/rtl/lbc_checker.sv
// ----------------------------------------------------------------------------
// Buffer cache port checker
// Port-level checks on transfer sequencing, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lbc_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input lbc_pkg::lbc_out_t out_data
);

    // an item taken keeps in_ready low while it is worked
    `LBC_ASSERT_NEXT(a_busy_after_in, clk, rst_n, in_valid && in_ready, !in_ready)

    // a new result shows up as the block returns to accepting
    `LBC_ASSERT_SAME(a_result_frees_input, clk, rst_n, $rose(out_valid), in_ready)

    // a result not yet taken holds
    `LBC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
                     out_valid && $stable(out_data))

endmodule

bind lru_block_buffer_cache lbc_checker u_lbc_checker (.*);
